>>> rtl/core/swrc_pkg.sv
// shared constants and types of the sliding window range check
package swrc_pkg;

   localparam int CSR_INDEX_BITS     = 1;
   localparam int CSR_DATA_BITS      = 32;
   localparam int WINDOW_LENGTH_BITS = 7;
   localparam int RANGE_LIMIT_BITS   = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_LENGTH = 1'b0,
      CSR_RANGE_LIMIT   = 1'b1
   } csr_index_type;

   // per-cycle command to every cell of a queue
   typedef struct packed {
      logic age;     // bump the age of every entry
      logic shift;   // drop the head, every cell takes its right neighbor
      logic append;  // drop dominated tail entries and append the new sample
   } cell_ctrl_type;

endpackage

>>> rtl/core/swrc_req_if.sv
// sample item channel
interface swrc_req_if #(
   parameter int SAMPLE_BITS = 32
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

>>> rtl/core/swrc_rsp_if.sv
// result item channel
interface swrc_rsp_if #(
   parameter int SAMPLE_BITS = 32
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] window_max;
   logic [SAMPLE_BITS-1:0] window_min;
   logic                   window_full;
   logic                   range_ok;

   modport source (output valid, output window_max, output window_min,
                   output window_full, output range_ok, input ready);
   modport sink   (input valid, input window_max, input window_min,
                   input window_full, input range_ok, output ready);
endinterface

>>> rtl/core/swrc_cell.sv
// one entry of a monotonic queue
module swrc_cell #(
   parameter int SAMPLE_BITS = 32,
   parameter int AGE_BITS    = 7,
   parameter int AGE_LIMIT   = 64,
   parameter bit IS_MAX      = 1'b1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  swrc_pkg::cell_ctrl_type ctrl,
   input  logic [SAMPLE_BITS-1:0] new_value,
   input  logic                   prev_keep,
   input  logic                   next_valid,
   input  logic [SAMPLE_BITS-1:0] next_value,
   input  logic [AGE_BITS-1:0]    next_age,
   output logic                   valid,
   output logic [SAMPLE_BITS-1:0] value,
   output logic [AGE_BITS-1:0]    age,
   output logic                   keep
);
   import swrc_pkg::*;

   logic                   valid_ff, valid_in;
   logic [SAMPLE_BITS-1:0] value_ff, value_in;
   logic [AGE_BITS-1:0]    age_ff, age_in;
   logic                   dominated;

   // ties go to the newer sample in both orderings
   always_comb begin
      if (IS_MAX) begin
         dominated = $signed(value_ff) <= $signed(new_value);
      end else begin
         dominated = $signed(value_ff) >= $signed(new_value);
      end
   end

   assign keep = valid_ff && !dominated;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      age_in   = age_ff;
      if (ctrl.age) begin
         if (age_ff < AGE_BITS'(AGE_LIMIT)) begin
            age_in = age_ff + AGE_BITS'(1);
         end
      end else if (ctrl.shift) begin
         valid_in = next_valid;
         value_in = next_value;
         age_in   = next_age;
      end else if (ctrl.append && !keep) begin
         // first cell past the kept run takes the sample, the rest empty out
         if (prev_keep) begin
            valid_in = 1'b1;
            value_in = new_value;
            age_in   = '0;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      age_ff   <= age_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign age   = age_ff;

endmodule

>>> rtl/core/swrc_queue.sv
// monotonic queue built as a row of cells, head at cell 0
module swrc_queue #(
   parameter int SAMPLE_BITS = 32,
   parameter int MAX_WINDOW  = 64,
   parameter int AGE_BITS    = 7,
   parameter bit IS_MAX      = 1'b1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  swrc_pkg::cell_ctrl_type ctrl,
   input  logic [SAMPLE_BITS-1:0] new_value,
   input  logic [AGE_BITS-1:0]    window_len,
   output logic [SAMPLE_BITS-1:0] head_value,
   output logic                   head_expired
);
   import swrc_pkg::*;

   logic                   valid [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0] value [MAX_WINDOW];
   logic [AGE_BITS-1:0]    age   [MAX_WINDOW];
   logic                   keep  [MAX_WINDOW];

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic                   prev_keep;
      logic                   next_valid;
      logic [SAMPLE_BITS-1:0] next_value;
      logic [AGE_BITS-1:0]    next_age;

      if (i == 0) begin : g_head
         assign prev_keep = 1'b1;
      end else begin : g_body
         assign prev_keep = keep[i-1];
      end

      if (i == MAX_WINDOW - 1) begin : g_tail
         assign next_valid = 1'b0;
         assign next_value = '0;
         assign next_age   = '0;
      end else begin : g_link
         assign next_valid = valid[i+1];
         assign next_value = value[i+1];
         assign next_age   = age[i+1];
      end

      swrc_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .AGE_BITS    (AGE_BITS),
         .AGE_LIMIT   (MAX_WINDOW),
         .IS_MAX      (IS_MAX)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_value  (new_value),
         .prev_keep  (prev_keep),
         .next_valid (next_valid),
         .next_value (next_value),
         .next_age   (next_age),
         .valid      (valid[i]),
         .value      (value[i]),
         .age        (age[i]),
         .keep       (keep[i])
      );
   end

   assign head_value   = value[0];
   assign head_expired = valid[0] && (age[0] >= window_len);

endmodule

>>> rtl/core/sliding_window_range_check.sv
// sliding window max / min range check: top level with sequencer and csr
// an accepted item passes ST_EXPIRE, where aged heads drop, then waits in ST_FINISH for a free result register
// one item in flight at a time: a new item is accepted only in ST_IDLE, after the last result is loaded
// both queues drop one head per cycle in parallel, so after the window is shortened an item stays in ST_EXPIRE longer
// reset (synchronous, active high) clears cell valid bits, sample count and result valid, sets window length to 1
// and range limit to 0; no clearing pass: the queues are empty right after reset
module sliding_window_range_check #(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   swrc_req_if.sink                             req_if,
   swrc_rsp_if.source                           rsp_if,
   input  logic                                 csr_write_en,
   input  logic [swrc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [swrc_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);
   import swrc_pkg::*;

   // age and length counters must hold MAX_WINDOW itself
   localparam int LEN_BITS   = $clog2(MAX_WINDOW + 1);
   localparam int CMP_BITS   = (LEN_BITS > WINDOW_LENGTH_BITS) ? LEN_BITS : WINDOW_LENGTH_BITS;
   localparam int DIFF_BITS  = SAMPLE_BITS + 1;
   localparam int LIMIT_BITS = (DIFF_BITS > RANGE_LIMIT_BITS) ? DIFF_BITS : RANGE_LIMIT_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,     // waiting for an item
      ST_EXPIRE,   // drop aged heads one per cycle, then append
      ST_FINISH    // heads settled, build the result item
   } state_type;

   state_type                     state_ff;
   logic [WINDOW_LENGTH_BITS-1:0] window_length_ff;
   logic [RANGE_LIMIT_BITS-1:0]   range_limit_ff;
   logic [SAMPLE_BITS-1:0]        sample_ff;
   logic [LEN_BITS-1:0]           seen_ff, seen_in;
   logic                          rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]        window_max_ff, window_min_ff;
   logic                          window_full_ff, range_ok_ff;

   logic                          req_accept;
   logic                          out_free;
   logic [CMP_BITS-1:0]           wl_cmp, len_cmp;
   logic [LEN_BITS-1:0]           window_len;
   cell_ctrl_type                 max_ctrl, min_ctrl;
   logic [SAMPLE_BITS-1:0]        max_head, min_head;
   logic                          max_expired, min_expired;
   logic [DIFF_BITS-1:0]          head_diff;
   logic                          full_now, ok_now;

   // effective window length: zero acts as one, long values clamp to MAX_WINDOW
   always_comb begin
      wl_cmp = CMP_BITS'(window_length_ff);
      if (wl_cmp == '0) begin
         len_cmp = CMP_BITS'(1);
      end else if (wl_cmp > CMP_BITS'(MAX_WINDOW)) begin
         len_cmp = CMP_BITS'(MAX_WINDOW);
      end else begin
         len_cmp = wl_cmp;
      end
      window_len = LEN_BITS'(len_cmp);
   end

   // input side: one item in flight at a time
   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;

   // queue commands: ages bump on accept, heads drop while too old,
   // append once neither head is out of the window
   always_comb begin
      max_ctrl.age    = req_accept;
      min_ctrl.age    = req_accept;
      max_ctrl.shift  = (state_ff == ST_EXPIRE) && max_expired;
      min_ctrl.shift  = (state_ff == ST_EXPIRE) && min_expired;
      max_ctrl.append = (state_ff == ST_EXPIRE) && !max_expired && !min_expired;
      min_ctrl.append = max_ctrl.append;
   end

   swrc_queue #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_WINDOW  (MAX_WINDOW),
      .AGE_BITS    (LEN_BITS),
      .IS_MAX      (1'b1)
   ) u_max_queue (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (max_ctrl),
      .new_value    (sample_ff),
      .window_len   (window_len),
      .head_value   (max_head),
      .head_expired (max_expired)
   );

   swrc_queue #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_WINDOW  (MAX_WINDOW),
      .AGE_BITS    (LEN_BITS),
      .IS_MAX      (1'b0)
   ) u_min_queue (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (min_ctrl),
      .new_value    (sample_ff),
      .window_len   (window_len),
      .head_value   (min_head),
      .head_expired (min_expired)
   );

   // sample count saturates at MAX_WINDOW
   always_comb begin
      if (seen_ff < LEN_BITS'(MAX_WINDOW)) begin
         seen_in = seen_ff + LEN_BITS'(1);
      end else begin
         seen_in = seen_ff;
      end
   end

   // exact spread max - min, never negative, one bit wider than a sample
   assign head_diff = {max_head[SAMPLE_BITS-1], max_head} - {min_head[SAMPLE_BITS-1], min_head};
   assign full_now  = seen_in >= window_len;
   assign ok_now    = full_now &&
                      (LIMIT_BITS'(head_diff) <= LIMIT_BITS'(range_limit_ff));

   // output register frees when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_LENGTH_BITS'(1);
         range_limit_ff   <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: begin
               window_length_ff <= csr_write_data[WINDOW_LENGTH_BITS-1:0];
            end
            CSR_RANGE_LIMIT: begin
               range_limit_ff <= csr_write_data[RANGE_LIMIT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // accepted sample payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff <= req_if.sample;
      end
   end

   // sequencer, sample count and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in ST_FINISH the result load below decides the valid bit
         if (rsp_valid_ff && rsp_if.ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff <= ST_EXPIRE;
               end
            end
            ST_EXPIRE: begin
               if (!max_expired && !min_expired) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  window_max_ff  <= max_head;
                  window_min_ff  <= min_head;
                  window_full_ff <= full_now;
                  range_ok_ff    <= ok_now;
                  seen_ff        <= seen_in;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.window_max  = window_max_ff;
   assign rsp_if.window_min  = window_min_ff;
   assign rsp_if.window_full = window_full_ff;
   assign rsp_if.range_ok    = range_ok_ff;

endmodule
